// ===== sv/espe_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder period speed estimator package
// Shared widths, register indexes, request codes and status types.
// ----------------------------------------------------------------------------
package espe_pkg;

	localparam int NUM_W      = 48;                   // speed numerator width
	localparam int SPEED_W    = 32;                   // Q16.16 speed width
	localparam int DECAY_W    = 16;                   // Q0.16 decay factor width
	localparam int TIME_IN_W  = 32;                   // edge timestamp field width
	localparam int CFG_W      = 48;                   // widest register
	localparam int CFG_IDX_W  = 1;                    // two registers
	localparam int DIV_CNT_W  = $clog2(NUM_W);        // one quotient bit per cycle
	localparam int MUL_CNT_W  = $clog2(DECAY_W);      // one factor bit per cycle

	localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd63677;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_NUM = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 1'd1;

	// request codes
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} espe_div_stat_t;

endpackage

// ===== sv/espe_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one edge or tick request.
// ----------------------------------------------------------------------------
interface espe_req_if;
	logic                             valid;
	logic                             ready;
	logic                             opcode;
	logic [espe_pkg::TIME_IN_W-1:0]   edge_time;

	modport source (output valid, output opcode, output edge_time, input ready);
	modport sink   (input valid, input opcode, input edge_time, output ready);
endinterface

// ===== sv/espe_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the speed estimate after each request.
// ----------------------------------------------------------------------------
interface espe_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [espe_pkg::SPEED_W-1:0]   speed;

	modport source (output valid, output speed, input ready);
	modport sink   (input valid, input speed, output ready);
endinterface

// ===== sv/espe_div.sv =====
// ----------------------------------------------------------------------------
// Serial restoring divider
// One quotient bit per cycle; quotient saturates to all ones on overflow.
// ----------------------------------------------------------------------------
module espe_div #(
	parameter int DEN_W = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [espe_pkg::NUM_W-1:0]      numerator,
	input  logic [DEN_W-1:0]                denominator,
	output espe_pkg::espe_div_stat_t        stat,
	output logic [espe_pkg::SPEED_W-1:0]    quotient
);

	localparam logic [espe_pkg::DIV_CNT_W-1:0] LAST_STEP =
		espe_pkg::DIV_CNT_W'(espe_pkg::NUM_W - 1);

	logic                              busy_q;
	logic                              done_q;
	logic [espe_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [espe_pkg::NUM_W-1:0]        num_sr_q;
	logic [DEN_W-1:0]                  den_q;
	logic [DEN_W-1:0]                  rem_q;
	logic [espe_pkg::SPEED_W-1:0]      quo_q;
	logic                              ovf_q;

	logic [DEN_W:0]                    trial;
	logic [DEN_W:0]                    diff;
	logic                              qbit;

	always_comb begin
		trial = {rem_q, num_sr_q[espe_pkg::NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift numerator bits in, quotient bits out
	always_ff @(posedge clk) begin
		if (start) begin
			num_sr_q <= numerator;
			den_q    <= denominator;
			rem_q    <= '0;
			quo_q    <= '0;
			ovf_q    <= 1'b0;
		end else if (busy_q) begin
			num_sr_q <= {num_sr_q[espe_pkg::NUM_W-2:0], 1'b0};
			rem_q    <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q    <= {quo_q[espe_pkg::SPEED_W-2:0], qbit};
			ovf_q    <= ovf_q | quo_q[espe_pkg::SPEED_W-1];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = ovf_q ? '1 : quo_q;

endmodule

// ===== sv/encoder_period_speed_estimator.sv =====
// ----------------------------------------------------------------------------
// Encoder period speed estimator
// Wheel speed from encoder edge periods, with per-tick decay.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: opcode edge with a timer timestamp, or opcode
//   tick. rsp returns exactly one speed (unsigned Q16.16) per request.
//   cfg_we/cfg_index/cfg_data write speed_numerator (index 0) and
//   decay_factor (index 1); write only while no request is in flight.
// Timing:
//   An edge after the first runs a serial divider, one quotient bit per
//   cycle over the 48 numerator bits; the result is loaded in ST_LOAD and
//   the next request is taken back in ST_IDLE. A tick runs a shift-add
//   multiply, one decay factor bit per cycle, then loads its result the same
//   way. The first edge after reset only stores its time and goes straight
//   to ST_LOAD. A new request is taken only once the last one is through.
// Reset:
//   arst_n clears the speed, forgets the previous edge and restores the
//   register defaults (numerator 0, decay 63677).
// Back pressure:
//   The result sits in an output register; a new request is accepted and
//   computed while it waits, and the next result holds until rsp drains.
// ----------------------------------------------------------------------------
module encoder_period_speed_estimator #(
	parameter int TICK_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	espe_req_if.sink                            req,
	espe_rsp_if.source                          rsp,
	input  logic                                cfg_we,
	input  logic [espe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [espe_pkg::CFG_W-1:0]          cfg_data
);

	// stored timestamp bits: the field width or the timer width, whichever less
	localparam int TIME_W = (TICK_BITS < espe_pkg::TIME_IN_W) ? TICK_BITS
		: espe_pkg::TIME_IN_W;
	localparam logic [espe_pkg::MUL_CNT_W-1:0] MUL_LAST =
		espe_pkg::MUL_CNT_W'(espe_pkg::DECAY_W - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_LOAD
	} state_t;

	state_t                            state_q;
	logic                              rsp_valid_q;

	// configuration
	logic [espe_pkg::NUM_W-1:0]        speed_num_q;
	logic [espe_pkg::DECAY_W-1:0]      decay_q;

	// estimator state
	logic [TIME_W-1:0]                 prev_time_q;
	logic                              prev_valid_q;
	logic [espe_pkg::SPEED_W-1:0]      speed_value_q;
	logic [espe_pkg::SPEED_W-1:0]      next_q;

	// decay multiplier
	logic [espe_pkg::DECAY_W-1:0]      fac_sr_q;
	logic [espe_pkg::SPEED_W-1:0]      acc_q;
	logic [espe_pkg::MUL_CNT_W-1:0]    mcnt_q;
	logic [espe_pkg::SPEED_W:0]        mul_sum;

	logic                              accept;
	logic                              is_edge;
	logic [TICK_BITS-1:0]              t_ext;
	logic [TICK_BITS-1:0]              delta;
	logic                              div_start;
	espe_pkg::espe_div_stat_t          div_stat;
	logic [espe_pkg::SPEED_W-1:0]      div_quo;
	logic                              rsp_free;

	always_comb begin
		req.ready = (state_q == ST_IDLE);
		accept    = req.valid & req.ready;
		is_edge   = (req.opcode == espe_pkg::OP_EDGE);
		t_ext     = TICK_BITS'(req.edge_time[TIME_W-1:0]);
		// period modulo the timer range
		delta     = t_ext - TICK_BITS'(prev_time_q);
		div_start = accept & is_edge & prev_valid_q;
		mul_sum   = {1'b0, acc_q} + (fac_sr_q[0] ? {1'b0, speed_value_q} : '0);
		rsp_free  = !rsp_valid_q || rsp.ready;
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.speed = speed_value_q;

	espe_div #(
		.DEN_W (TICK_BITS)
	) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (div_start),
		.numerator   (speed_num_q),
		.denominator (delta),
		.stat        (div_stat),
		.quotient    (div_quo)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_num_q <= '0;
			decay_q     <= espe_pkg::DECAY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				espe_pkg::REG_SPEED_NUM: speed_num_q <= cfg_data[espe_pkg::NUM_W-1:0];
				espe_pkg::REG_DECAY:     decay_q     <= cfg_data[espe_pkg::DECAY_W-1:0];
				default:                 ;
			endcase
		end
	end

	// sequencer: state, result register and estimator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rsp_valid_q   <= 1'b0;
			prev_time_q   <= '0;
			prev_valid_q  <= 1'b0;
			speed_value_q <= '0;
		end else begin
			// raise the result on load, drop it once taken
			if (state_q == ST_LOAD && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_edge) begin
							prev_time_q  <= req.edge_time[TIME_W-1:0];
							prev_valid_q <= 1'b1;
							// first edge only records its time
							state_q      <= prev_valid_q ? ST_DIV : ST_LOAD;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_LOAD;
					end
				end
				ST_MUL: begin
					if (mcnt_q == MUL_LAST) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					// hold the new speed until the result register is free
					if (rsp_free) begin
						speed_value_q <= next_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: decay shift-add and next speed capture
	always_ff @(posedge clk) begin
		if (accept) begin
			fac_sr_q <= decay_q;
			acc_q    <= '0;
			mcnt_q   <= '0;
			next_q   <= speed_value_q;
		end else if (state_q == ST_MUL) begin
			// add partial product, shift one factor bit out
			fac_sr_q <= fac_sr_q >> 1;
			acc_q    <= mul_sum[espe_pkg::SPEED_W:1];
			mcnt_q   <= mcnt_q + 1'b1;
			if (mcnt_q == MUL_LAST) begin
				next_q <= mul_sum[espe_pkg::SPEED_W:1];
			end
		end else if (state_q == ST_DIV && div_stat.done) begin
			next_q <= div_quo;
		end
	end

`ifndef SYNTH
	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_stat.busy)
		else $error("divider busy while idle");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("divider finished outside divide state");

	a_edge_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == ST_DIV) && div_stat.busy)
		else $error("edge did not start the divider");

	a_tick_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_edge) |=> (state_q == ST_MUL))
		else $error("tick did not start the multiply");

	a_speed_moves_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(speed_value_q) |-> rsp_valid_q && $past(state_q == ST_LOAD))
		else $error("speed changed without a new result");
`endif

endmodule
